>>> rtl/core/adsb_id_pkg.sv
// ----------------------------------------------------------------------------
// adsb_id_pkg
// Shared types, constants and the parity step of the identification framer.
// ----------------------------------------------------------------------------
package adsb_id_pkg;

    localparam int unsigned NumChars   = 8;
    localparam int unsigned CodeW      = 6;
    localparam int unsigned AddrW      = 24;
    localparam int unsigned CrcW       = 24;
    localparam int unsigned DataW      = 88;
    localparam int unsigned PosW       = 4;

    localparam logic [7:0]      HdrDfCa   = 8'h8D;
    localparam logic [7:0]      HdrTc     = 8'h20;
    localparam logic [CrcW-1:0] ParityGen = 24'hFFF409;

    localparam logic [PosW-1:0] LastDataPos = 4'd10;
    localparam logic [PosW-1:0] LastPos     = 4'd13;

    localparam logic [CodeW-1:0] CodeSpace = 6'd32;
    localparam logic [CodeW-1:0] CodeHash  = 6'd0;

    typedef logic [CodeW-1:0] char_code_t;

    typedef struct packed {
        logic [AddrW-1:0]            addr;
        logic [NumChars*CodeW-1:0]   codes;
    } frame_t;

    // one byte of the Mode S parity division, MSB first
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] rem_in,
                                                 input logic [7:0]      data);
        logic [CrcW-1:0] rem;
        rem = rem_in ^ {data, 16'h0000};
        for (int b = 0; b < 8; b++)
        begin
            if (rem[CrcW-1])
                rem = {rem[CrcW-2:0], 1'b0} ^ ParityGen;
            else
                rem = {rem[CrcW-2:0], 1'b0};
        end
        return rem;
    endfunction

endpackage

>>> rtl/core/adsb_id_in_if.sv
// ----------------------------------------------------------------------------
// adsb_id_in_if
// Request channel: aircraft address and eight callsign characters.
// ----------------------------------------------------------------------------
interface adsb_id_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] aircraft_address;
    logic [7:0]  char_0;
    logic [7:0]  char_1;
    logic [7:0]  char_2;
    logic [7:0]  char_3;
    logic [7:0]  char_4;
    logic [7:0]  char_5;
    logic [7:0]  char_6;
    logic [7:0]  char_7;

    modport source (output valid, aircraft_address, char_0, char_1, char_2, char_3,
                    char_4, char_5, char_6, char_7, input ready);
    modport sink   (input valid, aircraft_address, char_0, char_1, char_2, char_3,
                    char_4, char_5, char_6, char_7, output ready);
endinterface

>>> rtl/core/adsb_id_out_if.sv
// ----------------------------------------------------------------------------
// adsb_id_out_if
// Byte channel: one frame byte per word with its position and a last flag.
// ----------------------------------------------------------------------------
interface adsb_id_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [3:0] byte_position;
    logic       last_byte;

    modport source (output valid, frame_byte, byte_position, last_byte, input ready);
    modport sink   (input valid, frame_byte, byte_position, last_byte, output ready);
endinterface

>>> rtl/core/adsb_id_char_lane.sv
// ----------------------------------------------------------------------------
// adsb_id_char_lane
// Maps one ASCII character to its 6-bit ADS-B identification code.
// ----------------------------------------------------------------------------
module adsb_id_char_lane
    import adsb_id_pkg::*;
(
    input  logic [7:0]  ch,
    output char_code_t  code
);

    always_comb
    begin
        if (ch >= 8'h41 && ch <= 8'h5A)
            code = CodeW'(ch - 8'h40);
        else if (ch >= 8'h30 && ch <= 8'h39)
            code = ch[CodeW-1:0];
        else if (ch == 8'h23)
            code = CodeHash;
        else
            code = CodeSpace;
    end

endmodule

>>> rtl/core/adsb_id_ser.sv
// ----------------------------------------------------------------------------
// adsb_id_ser
// Frame serializer: shifts out the 11 data bytes, folds each into the parity
// remainder as it leaves, then shifts out the three parity bytes.
// ----------------------------------------------------------------------------
module adsb_id_ser
    import adsb_id_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load_valid,
    output logic           load_ready,
    input  frame_t         load_frame,
    adsb_id_out_if.source  dst
);

    logic                  busy_reg, busy_next;
    logic [PosW-1:0]       pos_reg, pos_next;
    logic [DataW-1:0]      data_reg, data_next;
    logic [CrcW-1:0]       crc_reg, crc_next;
    logic                  fire;
    logic                  last;
    logic [CrcW-1:0]       crc_step;

    assign fire     = busy_reg && dst.ready;
    assign last     = (pos_reg == LastPos);
    assign crc_step = crc_byte(crc_reg, data_reg[DataW-1 -: 8]);

    assign load_ready        = !busy_reg || (fire && last);
    assign dst.valid         = busy_reg;
    assign dst.frame_byte    = data_reg[DataW-1 -: 8];
    assign dst.byte_position = pos_reg;
    assign dst.last_byte     = last;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        data_next = data_reg;
        crc_next  = crc_reg;
        if (load_valid && load_ready)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            data_next = {HdrDfCa, load_frame.addr, HdrTc, load_frame.codes};
            crc_next  = '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LastDataPos)
                    data_next = {crc_step, {(DataW-CrcW){1'b0}}};
                else
                    data_next = {data_reg[DataW-9:0], 8'h00};
                if (pos_reg <= LastDataPos)
                    crc_next = crc_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        crc_reg  <= crc_next;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg <= LastPos)
        else $error("byte position out of range");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last) |=> (busy_reg && pos_reg == $past(pos_reg) + 1'b1))
        else $error("byte position did not advance");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !dst.ready) |=> (busy_reg && $stable(pos_reg) && $stable(data_reg)))
        else $error("serializer moved while stalled");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && load_ready) |=> (busy_reg && pos_reg == '0))
        else $error("frame load did not restart at byte zero");
`endif

endmodule

>>> rtl/core/adsb_identification_frame_builder.sv
// ----------------------------------------------------------------------------
// adsb_identification_frame_builder
// ADS-B extended squitter identification frame builder with Mode S parity.
// ----------------------------------------------------------------------------
// Usage:
//   id_in takes one request word: a 24-bit aircraft address and eight ASCII
//   callsign characters. byte_out returns the 14-byte frame as 14 words,
//   byte 0 first, each with its position; last_byte marks byte 13.
//   Eight character lanes encode the callsign in the accepting edge's cycle
//   and the packed frame is held in a one-deep request register.
//   When the serializer is idle, the request passes from the request register
//   into the serializer's data register, which drives byte 0.
//   The output serializer sends one byte per cycle while the receiver holds
//   ready high; the parity is folded in byte by byte as the data bytes leave.
//   One request can wait in the request register while a frame is still
//   being sent, so back-to-back requests run with no gap between frames.
//   When the receiver drops ready the current byte holds and the request
//   register fills; id_in.ready then falls until the serializer takes it.
//   Reset clears the valid flags and the byte counter; no frame is pending.
// ----------------------------------------------------------------------------
module adsb_identification_frame_builder
    import adsb_id_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    adsb_id_in_if.sink    id_in,
    adsb_id_out_if.source byte_out
);

    logic [7:0]  chars [NumChars];
    char_code_t  codes [NumChars];
    frame_t      merged;
    frame_t      pend_reg;
    logic        pend_valid_reg, pend_valid_next;
    logic        ld_ready;
    logic        in_fire;

    assign chars[0] = id_in.char_0;
    assign chars[1] = id_in.char_1;
    assign chars[2] = id_in.char_2;
    assign chars[3] = id_in.char_3;
    assign chars[4] = id_in.char_4;
    assign chars[5] = id_in.char_5;
    assign chars[6] = id_in.char_6;
    assign chars[7] = id_in.char_7;

    for (genvar g = 0; g < NumChars; g++)
    begin : g_lane
        adsb_id_char_lane u_lane (
            .ch   (chars[g]),
            .code (codes[g])
        );
        // first character lands in the top bits
        assign merged.codes[(NumChars-g)*CodeW-1 -: CodeW] = codes[g];
    end
    assign merged.addr = id_in.aircraft_address;

    assign id_in.ready = !pend_valid_reg || ld_ready;
    assign in_fire     = id_in.valid && id_in.ready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (in_fire)
            pend_valid_next = 1'b1;
        else if (ld_ready)
            pend_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else
            pend_valid_reg <= pend_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            pend_reg <= merged;
    end

    adsb_id_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (pend_valid_reg),
        .load_ready (ld_ready),
        .load_frame (pend_reg),
        .dst        (byte_out)
    );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives callsign requests into the identification frame builder and checks
// every frame byte, its position and the last flag against frames computed
// here from the address and characters; idle cycles on both sides are random except in the no-gap phases.
// ----------------------------------------------------------------------------
module testbench;
    import adsb_id_pkg::*;

    localparam int unsigned FrameBytes  = 14;
    localparam int unsigned DataBytes   = 11;
    localparam int unsigned RandomReqs  = 255;
    localparam int unsigned DrainCycles = 40;
    localparam int unsigned CycleLimit  = 400000;

    typedef struct packed {
        logic [23:0]     addr;
        logic [7:0][7:0] chars;
    } callsign_req_t;

    typedef logic [FrameBytes-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] pos;
        logic       last;
    } frame_word_t;

    class frame_scoreboard;
        frame_word_t pending_words[$];
        int          errors;

        function char_code_t char_to_code(logic [7:0] c);
            if (c >= 8'h41 && c <= 8'h5A)
                return char_code_t'(c - 8'h40);
            if (c >= 8'h30 && c <= 8'h39)
                return char_code_t'(c);
            if (c == 8'h23)
                return CodeHash;
            return CodeSpace;
        endfunction

        function frame_bytes_t build_frame(callsign_req_t r);
            frame_bytes_t fr;
            logic [47:0]  codes;
            logic [23:0]  rem;
            fr[0] = HdrDfCa;
            fr[1] = r.addr[23:16];
            fr[2] = r.addr[15:8];
            fr[3] = r.addr[7:0];
            fr[4] = HdrTc;
            codes = '0;
            for (int i = 0; i < 8; i++)
                codes = {codes[41:0], char_to_code(r.chars[i])};
            for (int i = 0; i < 6; i++)
                fr[5+i] = codes[47-8*i -: 8];
            // Mode S parity, long division MSB first over the 88 data bits
            rem = '0;
            for (int i = 0; i < DataBytes; i++)
            begin
                rem = rem ^ {fr[i], 16'h0000};
                for (int b = 0; b < 8; b++)
                    rem = rem[23] ? ({rem[22:0], 1'b0} ^ ParityGen) : {rem[22:0], 1'b0};
            end
            fr[11] = rem[23:16];
            fr[12] = rem[15:8];
            fr[13] = rem[7:0];
            return fr;
        endfunction

        function void note_request(callsign_req_t r);
            frame_bytes_t fr;
            frame_word_t  w;
            fr = build_frame(r);
            for (int i = 0; i < FrameBytes; i++)
            begin
                w.data = fr[i];
                w.pos  = 4'(i);
                w.last = (i == FrameBytes - 1);
                pending_words.push_back(w);
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(logic [7:0] data, logic [3:0] pos, logic last);
            frame_word_t w;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word byte=%02h pos=%0d last=%0b", data, pos, last));
                return;
            end
            w = pending_words.pop_front();
            if (data !== w.data)
                report($sformatf("frame_byte %02h, want %02h (pos %0d)", data, w.data, w.pos));
            if (pos !== w.pos)
                report($sformatf("byte_position %0d, want %0d", pos, w.pos));
            if (last !== w.last)
                report($sformatf("last_byte %0b, want %0b (pos %0d)", last, w.last, w.pos));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   cycles;

    adsb_id_in_if  id_in();
    adsb_id_out_if byte_out();

    frame_scoreboard sb = new();

    adsb_identification_frame_builder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .id_in    (id_in),
        .byte_out (byte_out)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[adsb_identification_frame_builder] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && id_in.valid && id_in.ready)
            sb.note_request('{addr: id_in.aircraft_address,
                              chars: {id_in.char_7, id_in.char_6, id_in.char_5, id_in.char_4,
                                      id_in.char_3, id_in.char_2, id_in.char_1, id_in.char_0}});
        if (rst_n && byte_out.valid && byte_out.ready)
            sb.check_word(byte_out.frame_byte, byte_out.byte_position, byte_out.last_byte);
    end

    // receiver: random stall before each word
    initial
    begin
        int stall;
        byte_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                byte_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            byte_out.ready <= 1'b1;
            do
                @(posedge clk);
            while (!byte_out.valid);
        end
    end

    function automatic callsign_req_t make_req(logic [23:0] addr, logic [63:0] text);
        callsign_req_t r;
        r.addr = addr;
        for (int i = 0; i < 8; i++)
            r.chars[i] = text[63-8*i -: 8];
        return r;
    endfunction

    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 8'($urandom_range(8'h41, 8'h5A));
        if (sel < 60)
            return 8'($urandom_range(8'h30, 8'h39));
        if (sel < 72)
            return 8'h20;
        if (sel < 77)
            return 8'h23;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [23:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    task send_request(callsign_req_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            id_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        id_in.valid            <= 1'b1;
        id_in.aircraft_address <= r.addr;
        id_in.char_0           <= r.chars[0];
        id_in.char_1           <= r.chars[1];
        id_in.char_2           <= r.chars[2];
        id_in.char_3           <= r.chars[3];
        id_in.char_4           <= r.chars[4];
        id_in.char_5           <= r.chars[5];
        id_in.char_6           <= r.chars[6];
        id_in.char_7           <= r.chars[7];
        do
            @(posedge clk);
        while (!id_in.ready);
    endtask

    initial
    begin
        callsign_req_t r;
        cycles                 <= 0;
        rst_n                  <= 1'b0;
        no_gaps                 = 1'b0;
        id_in.valid            <= 1'b0;
        id_in.aircraft_address <= '0;
        id_in.char_0           <= '0;
        id_in.char_1           <= '0;
        id_in.char_2           <= '0;
        id_in.char_3           <= '0;
        id_in.char_4           <= '0;
        id_in.char_5           <= '0;
        id_in.char_6           <= '0;
        id_in.char_7           <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // letter boundaries, digits, hash, space, control and high codes
        send_request(make_req(24'h000000, "AZ@[`{ #"));
        send_request(make_req(24'hFFFFFF, "09/:#   "));
        send_request(make_req(24'h4840D6, "KLM1234 "));
        send_request(make_req(24'hABCDEF, 64'h0000_0000_0000_0000));
        send_request(make_req(24'h123456, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(make_req(24'h800000, 64'h7F80_2023_415A_3039));
        send_request(make_req(24'h000001, "azAZaz09"));
        send_request(make_req(24'h555555, "########"));
        send_request(make_req(24'hAAAAAA, "        "));
        send_request(make_req(24'h0F0F0F, "ZZZZZZZZ"));
        send_request(make_req(24'hF0F0F0, "99999999"));
        send_request(make_req(24'h7FFFFF, 64'h0102_0304_0506_0708));
        send_request(make_req(24'hC0FFEE, "N123AB  "));
        send_request(make_req(24'h3C6586, "DLH4AB~!"));

        for (int k = 0; k < RandomReqs; k++)
        begin
            no_gaps = ((k / 40) % 3 == 1);
            r.addr = pick_addr();
            for (int i = 0; i < 8; i++)
                r.chars[i] = pick_char();
            send_request(r);
        end
        id_in.valid <= 1'b0;
        no_gaps = 1'b0;

        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (sb.pending_words.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.pending_words.size()));
        if (sb.errors == 0)
            $display("[adsb_identification_frame_builder] OK");
        else
            $display("[adsb_identification_frame_builder] ERROR");
        $finish;
    end

endmodule
